@@ src/assert_macros.svh @@
// Assertion macros shared by the capture core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ src/rcpw_pkg.sv @@
// Types, register indexes and request codes for the pulse width capture core.
package rcpw_pkg;

    // Request kinds
    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_AVAIL   = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_WIDTH   = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 2'd2;

    // Reset values
    localparam logic [15:0] MIN_WIDTH_RST = 16'd600;
    localparam logic [15:0] MAX_WIDTH_RST = 16'd2400;
    localparam logic [7:0]  ALL_CLIENTS   = 8'hFF;

    typedef struct packed {
        logic [1:0]  req_type;
        logic        pin_level;
        logic [31:0] now_us;
        logic [7:0]  now_ms;
        logic [2:0]  client_index;
        logic [7:0]  timeout_limit_ms;
    } rcpw_in_t;

    typedef struct packed {
        logic        pulse_valid;
        logic        timed_out;
        logic        level_at_timeout;
        logic [15:0] width_value_us;
        logic [31:0] start_value_us;
    } rcpw_out_t;

    typedef struct packed {
        logic [15:0] min_width_us;
        logic [15:0] max_width_us;
        logic        invert_level;
    } rcpw_cfg_t;

endpackage

@@ src/rcpw_cfg_regs.sv @@
// Configuration register file for the pulse width capture core.
module rcpw_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [rcpw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcpw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output rcpw_pkg::rcpw_cfg_t                 cfg
);
    import rcpw_pkg::*;

    rcpw_cfg_t cfg_reg;

    // Write the addressed register; ignore indexes beyond the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_width_us <= MIN_WIDTH_RST;
            cfg_reg.max_width_us <= MAX_WIDTH_RST;
            cfg_reg.invert_level <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MIN_WIDTH: cfg_reg.min_width_us <= cfg_wdata[15:0];
                CFG_MAX_WIDTH: cfg_reg.max_width_us <= cfg_wdata[15:0];
                CFG_INVERT:    cfg_reg.invert_level <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/rcpw_in_stage.sv @@
// Input register stage: captures one request transaction at a time.
module rcpw_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rcpw_pkg::rcpw_in_t  s_data,
    input  logic                advance,
    output logic                in_valid,
    output rcpw_pkg::rcpw_in_t  in_data
);
    import rcpw_pkg::*;

    logic     in_valid_reg;
    rcpw_in_t in_data_reg;
    logic     load;

    // Accept when empty or when the held item moves on this cycle
    assign s_ready = !in_valid_reg || advance;
    assign load    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (load) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Hold payload until the next transaction
    always_ff @(posedge aclk) begin
        if (load) begin
            in_data_reg <= s_data;
        end
    end

    assign in_valid = in_valid_reg;
    assign in_data  = in_data_reg;

endmodule

@@ src/rcpw_exec.sv @@
// Capture state and per-request result logic.
module rcpw_exec (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  rcpw_pkg::rcpw_in_t  in_data,
    input  rcpw_pkg::rcpw_cfg_t cfg,
    output rcpw_pkg::rcpw_out_t result
);
    import rcpw_pkg::*;

    logic [31:0] start_time_reg,  start_time_next;
    logic [15:0] pulse_width_reg, pulse_width_next;
    logic [7:0]  flags_reg,       flags_next;
    logic [7:0]  last_end_reg,    last_end_next;

    logic [15:0] span_us;
    logic [7:0]  elapsed_ms;
    logic [7:0]  client_mask;
    logic        width_ok;

    // Width wraps at 16 bits, so only the low halves take part
    assign span_us     = in_data.now_us[15:0] - start_time_reg[15:0];
    assign elapsed_ms  = in_data.now_ms - last_end_reg;
    assign client_mask = 8'b1 << in_data.client_index;
    assign width_ok    = (pulse_width_reg >= cfg.min_width_us) &&
                         (pulse_width_reg <= cfg.max_width_us);

    // Decode the request, update state and form the result
    always_comb begin
        start_time_next  = start_time_reg;
        pulse_width_next = pulse_width_reg;
        flags_next       = flags_reg;
        last_end_next    = last_end_reg;
        result           = '0;
        case (in_data.req_type)
            REQ_EDGE: begin
                if (in_data.pin_level ^ cfg.invert_level) begin
                    start_time_next = in_data.now_us;
                end else begin
                    pulse_width_next = span_us;
                    flags_next       = ALL_CLIENTS;
                    last_end_next    = in_data.now_ms;
                end
            end
            REQ_AVAIL: begin
                if ((flags_reg & client_mask) != 8'd0) begin
                    flags_next         = flags_reg & ~client_mask;
                    result.pulse_valid = width_ok;
                end
            end
            REQ_TIMEOUT: begin
                if (elapsed_ms >= in_data.timeout_limit_ms) begin
                    result.timed_out        = 1'b1;
                    result.level_at_timeout = in_data.pin_level;
                end
            end
            REQ_WIDTH: begin
                result.width_value_us = pulse_width_reg;
                result.start_value_us = start_time_reg;
            end
            default: ;
        endcase
    end

    // Commit state when the request moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_time_reg  <= '0;
            pulse_width_reg <= '0;
            flags_reg       <= '0;
            last_end_reg    <= '0;
        end else if (advance) begin
            start_time_reg  <= start_time_next;
            pulse_width_reg <= pulse_width_next;
            flags_reg       <= flags_next;
            last_end_reg    <= last_end_next;
        end
    end

endmodule

@@ src/rcpw_out_stage.sv @@
// Result register stage: holds one result transaction until taken.
module rcpw_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  rcpw_pkg::rcpw_out_t result,
    output logic                advance,
    output logic                m_valid,
    input  logic                m_ready,
    output rcpw_pkg::rcpw_out_t m_data
);
    import rcpw_pkg::*;

    logic      m_valid_reg;
    rcpw_out_t m_data_reg;

    // Move a request forward when the result slot is free or being drained
    assign advance = in_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/rc_pulse_width_capture_core.sv @@
// RC pulse width capture core: top level.
//
// Requests enter on s_valid/s_ready/s_data; each one gives exactly one result
// on m_valid/m_ready/m_data. An edge request (pin level plus us and ms time)
// starts or ends a pulse; an availability request tests and clears one
// client's ready flag and checks the width against the min/max registers; a
// timeout request compares elapsed ms since the last pulse end with a limit;
// a width request returns the last width and start time. Fields that do not
// belong to the request kind read as zero.
// The input register loads at the accepting edge; the state update and result
// logic then load the result register, which drives m_valid and m_data.
// Throughput is one transaction per cycle while m_ready stays high.
// When the receiver stalls, the result register holds and the input register
// takes one more request, after which s_ready drops until the result drains.
// Reset (aresetn low at a clock edge) empties both registers, clears the
// pulse state and client flags and loads the register defaults: min 600 us,
// max 2400 us, no inversion. Write cfg_* only while no request is in flight.
`include "assert_macros.svh"

module rc_pulse_width_capture_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rcpw_pkg::rcpw_in_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rcpw_pkg::rcpw_out_t             m_data,
    input  logic                            cfg_we,
    input  logic [rcpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcpw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import rcpw_pkg::*;

    rcpw_cfg_t cfg;
    rcpw_in_t  in_data;
    rcpw_out_t result;
    logic      in_valid;
    logic      advance;

    rcpw_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rcpw_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    rcpw_exec u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_data (in_data),
        .cfg     (cfg),
        .result  (result)
    );

    rcpw_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .result   (result),
        .advance  (advance),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // An empty input register always takes a transaction
    `ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !in_valid, s_ready)
    // A full pipe with a stalled receiver refuses input
    `ASSERT_SAME(a_stall_blocks, aclk, aresetn, in_valid && m_valid && !m_ready, !s_ready)
    // Timeout level is reported only together with a timeout
    `ASSERT_SAME(a_level_needs_timeout, aclk, aresetn, m_valid && m_data.level_at_timeout,
        m_data.timed_out)
    // An accepted result is replaced by the waiting request in the next cycle
    `ASSERT_NEXT(a_refill, aclk, aresetn, m_valid && m_ready && in_valid, m_valid)

endmodule

@@ sim/rc_pulse_width_capture_core_tb.sv @@
// Testbench for the RC pulse width capture core: directed and random requests checked in order.
`timescale 1ns / 1ps

module rc_pulse_width_capture_core_tb;
    import rcpw_pkg::*;

    // Mirror of the capture state; predicts one output per accepted request
    class pulse_width_mirror;
        logic [15:0] min_us;
        logic [15:0] max_us;
        logic        inv;
        logic [31:0] pulse_start;
        logic [15:0] meas_width;
        logic [7:0]  ready_flags;
        logic [7:0]  end_ms;
        rcpw_out_t   pending_outputs[$];
        int          mismatches;
        int          kind_count[4];
        int          valid_hits;
        int          timeout_hits;

        function new();
            min_us = MIN_WIDTH_RST;
            max_us = MAX_WIDTH_RST;
            inv = 1'b0;
            pulse_start = '0;
            meas_width = '0;
            ready_flags = '0;
            end_ms = '0;
            mismatches = 0;
            valid_hits = 0;
            timeout_hits = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void set_regs(logic [15:0] lo, logic [15:0] hi, logic invert);
            min_us = lo;
            max_us = hi;
            inv = invert;
        endfunction

        // Update the state for one accepted request and queue its output
        function void take_request(rcpw_in_t r);
            rcpw_out_t   o;
            logic [31:0] diff;
            logic [7:0]  elapsed;
            o = '0;
            kind_count[r.req_type]++;
            case (r.req_type)
                REQ_EDGE: begin
                    if ((r.pin_level ^ inv) == 1'b1) begin
                        pulse_start = r.now_us;
                    end else begin
                        diff = r.now_us - pulse_start;
                        meas_width = diff[15:0];
                        ready_flags = ALL_CLIENTS;
                        end_ms = r.now_ms;
                    end
                end
                REQ_AVAIL: begin
                    if (ready_flags[r.client_index]) begin
                        ready_flags[r.client_index] = 1'b0;
                        if (meas_width >= min_us && meas_width <= max_us) begin
                            o.pulse_valid = 1'b1;
                            valid_hits++;
                        end
                    end
                end
                REQ_TIMEOUT: begin
                    elapsed = r.now_ms - end_ms;
                    if (elapsed >= r.timeout_limit_ms) begin
                        o.timed_out = 1'b1;
                        o.level_at_timeout = r.pin_level;
                        timeout_hits++;
                    end
                end
                default: begin
                    o.width_value_us = meas_width;
                    o.start_value_us = pulse_start;
                end
            endcase
            pending_outputs.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_result(rcpw_out_t got);
            rcpw_out_t want;
            if (pending_outputs.size() == 0) begin
                $error("output transaction with no pending request: 0x%0h", got);
                mismatches++;
            end else begin
                want = pending_outputs.pop_front();
                compare_field("pulse_valid", want.pulse_valid, got.pulse_valid);
                compare_field("timed_out", want.timed_out, got.timed_out);
                compare_field("level_at_timeout", want.level_at_timeout, got.level_at_timeout);
                compare_field("width_value_us", want.width_value_us, got.width_value_us);
                compare_field("start_value_us", want.start_value_us, got.start_value_us);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rcpw_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rcpw_out_t             m_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    pulse_width_mirror capture_mirror = new();

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          reg_settings = 0;
    logic [31:0] sig_us = 32'd0;
    logic [7:0]  sig_ms = 8'd0;
    logic        in_pulse = 1'b0;

    rc_pulse_width_capture_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs
    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: check output transactions, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            capture_mirror.check_result(m_data);
        end
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one request after a random gap and hold it until accepted
    task automatic send_request(rcpw_in_t req);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (!s_ready);
        capture_mirror.take_request(req);
    endtask

    // Hold off the sender until every predicted output has arrived
    task automatic drain_results();
        s_valid <= 1'b0;
        while (capture_mirror.pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(logic [15:0] lo, logic [15:0] hi, logic invert);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MIN_WIDTH;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= CFG_MAX_WIDTH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= CFG_INVERT;
        cfg_wdata <= {15'd0, invert};
        @(posedge aclk);
        cfg_we <= 1'b0;
        capture_mirror.set_regs(lo, hi, invert);
        reg_settings++;
    endtask

    function automatic rcpw_in_t build_req(logic [1:0] kind, logic level, logic [31:0] us,
                                           logic [7:0] ms, logic [2:0] client,
                                           logic [7:0] limit);
        rcpw_in_t r;
        r.req_type = kind;
        r.pin_level = level;
        r.now_us = us;
        r.now_ms = ms;
        r.client_index = client;
        r.timeout_limit_ms = limit;
        return r;
    endfunction

    // Pulse length biased toward the width limits, with some wrap past 2^16
    function automatic logic [31:0] pick_pulse_len();
        logic [15:0] w;
        logic [31:0] len;
        case ($urandom_range(0, 5))
            0: w = 16'(capture_mirror.min_us + $urandom_range(0, 4) - 2);
            1: w = 16'(capture_mirror.max_us + $urandom_range(0, 4) - 2);
            2: w = 16'($urandom_range(0, 65535));
            5: w = 16'($urandom_range(0, 3));
            default: w = 16'($urandom_range(500, 2500));
        endcase
        len = {16'd0, w};
        if ($urandom_range(0, 7) == 0) len = len + 32'h10000 * $urandom_range(1, 3);
        return len;
    endfunction

    // Mostly well-formed pulse edges and plausible queries, some noise
    function automatic rcpw_in_t random_request();
        rcpw_in_t    r;
        int          pick;
        logic [31:0] step;
        logic [31:0] ms_step;
        logic [7:0]  d;
        r.pin_level = 1'($urandom_range(0, 1));
        r.now_us = $urandom;
        r.now_ms = 8'($urandom_range(0, 255));
        r.client_index = 3'($urandom_range(0, 7));
        r.timeout_limit_ms = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            r.req_type = REQ_EDGE;
            if (pick < 40) begin
                step = in_pulse ? pick_pulse_len() : $urandom_range(1, 30000);
                if ($urandom_range(0, 63) == 0) sig_us = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                sig_us = sig_us + step;
                ms_step = step / 1000;
                sig_ms = sig_ms + ms_step[7:0];
                r.pin_level = in_pulse ? capture_mirror.inv : ~capture_mirror.inv;
                // occasionally repeat a level
                if ($urandom_range(0, 9) == 0) r.pin_level = ~r.pin_level;
                in_pulse = r.pin_level ^ capture_mirror.inv;
                r.now_us = sig_us;
                r.now_ms = sig_ms;
            end
        end else if (pick < 70) begin
            r.req_type = REQ_AVAIL;
        end else if (pick < 88) begin
            r.req_type = REQ_TIMEOUT;
            d = 8'($urandom_range(0, 255));
            r.now_ms = capture_mirror.end_ms + d;
            if ($urandom_range(0, 1) == 1) begin
                r.timeout_limit_ms = 8'(d + $urandom_range(0, 2) - 1);
            end
        end else begin
            r.req_type = REQ_WIDTH;
        end
        return r;
    endfunction

    logic [15:0] phase_lo[5]  = '{16'd600, 16'd0, 16'd65535, 16'd1000, 16'd0};
    logic [15:0] phase_hi[5]  = '{16'd2400, 16'd65535, 16'd65535, 16'd2000, 16'd0};
    logic        phase_inv[5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    int          phase_idle[5]  = '{0, 51, 0, 26, 0};
    int          phase_stall[5] = '{0, 0, 51, 26, 0};

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset state, zero and full limits, wrap, repeated levels
        send_request(build_req(REQ_WIDTH, 1'b0, 32'd0, 8'd0, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd0, 8'd0));
        send_request(build_req(REQ_TIMEOUT, 1'b1, 32'd0, 8'd0, 3'd0, 8'd0));
        send_request(build_req(REQ_TIMEOUT, 1'b1, 32'd0, 8'd0, 3'd0, 8'hFF));
        send_request(build_req(REQ_EDGE, 1'b1, 32'hFFFF_FF00, 8'd10, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b1, 32'hFFFF_FFF0, 8'd10, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b0, 32'd1484, 8'd12, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b0, 32'd3484, 8'd14, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd7, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd7, 8'd0));
        send_request(build_req(REQ_WIDTH, 1'b0, 32'd0, 8'd0, 3'd0, 8'd0));
        // width equal to the minimum, then to the maximum, then just below the minimum
        send_request(build_req(REQ_EDGE, 1'b1, 32'd10000, 8'd18, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b0, 32'd10600, 8'd20, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd3, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b1, 32'd20000, 8'd28, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b0, 32'd22400, 8'd30, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd5, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b1, 32'd0, 8'd38, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b0, 32'd599, 8'd40, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd1, 8'd0));
        // timeout exactly at the limit, one short of it, and all-ones fields
        send_request(build_req(REQ_TIMEOUT, 1'b1, 32'd0, 8'd50, 3'd0, 8'd10));
        send_request(build_req(REQ_TIMEOUT, 1'b1, 32'd0, 8'd50, 3'd0, 8'd11));
        send_request(build_req(REQ_TIMEOUT, 1'b1, 32'hFFFF_FFFF, 8'hFF, 3'd7, 8'hFF));
        send_request(build_req(REQ_WIDTH, 1'b1, 32'hFFFF_FFFF, 8'hFF, 3'd7, 8'hFF));

        // Crossed limits with inverted level: flag clears, width never valid
        drain_results();
        program_regs(16'd3000, 16'd100, 1'b1);
        send_request(build_req(REQ_EDGE, 1'b0, 32'd100, 8'd1, 3'd0, 8'd0));
        send_request(build_req(REQ_EDGE, 1'b1, 32'd1100, 8'd2, 3'd0, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd2, 8'd0));
        send_request(build_req(REQ_AVAIL, 1'b0, 32'd0, 8'd0, 3'd2, 8'd0));

        // Random phases with different register settings, idling and receiver stalls
        for (int p = 0; p < 5; p++) begin
            drain_results();
            if (p == 4) begin
                phase_lo[4] = 16'($urandom_range(0, 3000));
                phase_hi[4] = 16'($urandom_range(0, 3000));
                phase_inv[4] = 1'($urandom_range(0, 1));
                phase_idle[4] = $urandom_range(0, 60);
                phase_stall[4] = $urandom_range(0, 60);
            end
            program_regs(phase_lo[p], phase_hi[p], phase_inv[p]);
            in_pulse = 1'b0;
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int n = 0; n < 260; n++) begin
                if (p == 1 && n == 130) drain_results();
                send_request(random_request());
            end
        end

        // Wait for the last outputs, then idle with the receiver no longer stalling
        drain_results();
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);

        $display("Covered %0d edges, %0d availability, %0d timeout and %0d width requests",
                 capture_mirror.kind_count[REQ_EDGE], capture_mirror.kind_count[REQ_AVAIL],
                 capture_mirror.kind_count[REQ_TIMEOUT], capture_mirror.kind_count[REQ_WIDTH]);
        $display("Saw %0d valid pulses and %0d timeouts over %0d register settings",
                 capture_mirror.valid_hits, capture_mirror.timeout_hits, reg_settings);
        if (capture_mirror.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/rcpw_pkg.sv
src/rcpw_cfg_regs.sv
src/rcpw_in_stage.sv
src/rcpw_exec.sv
src/rcpw_out_stage.sv
src/rc_pulse_width_capture_core.sv
sim/rc_pulse_width_capture_core_tb.sv
